[src/crf_pkg.sv]
`timescale 1ns / 1ps
// crf_pkg: shared types, step codes and the crc-16 table for the request framer
// no dependencies

package crf_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // emit steps of one request
  localparam logic [2:0] PH_CMD  = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRCH = 3'd4;
  localparam logic [2:0] PH_CRCL = 3'd5;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] addr;
    logic [7:0] len_byte;
    logic [7:0] data;
    logic       first;
    logic       last;
  } item_t;

  // table entry: index in the top byte, shifted through the polynomial
  function automatic logic [15:0] crc_table(input logic [7:0] idx);
    logic [15:0] v;
    v = {idx, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    return crc_table(crc[15:8]) ^ {crc[7:0], 8'h00} ^ {8'h00, b};
  endfunction

endpackage

[src/crf_front.sv]
`timescale 1ns / 1ps
// crf_front: input register and frame position counter
// depends on crf_pkg

module crf_front #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         command_code,
  input  logic [7:0]         device_addr,
  input  logic [8:0]         payload_len,
  input  logic [7:0]         data_byte,
  output logic               item_valid,
  output crf_pkg::item_t     item,
  input  logic               item_take
);
  import crf_pkg::*;

  localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD);

  logic [8:0] byte_index;
  logic [8:0] len_eff;
  logic [8:0] len_m1;
  logic [8:0] idx_inc;
  logic       is_last;
  logic       accept;

  assign in_stall = item_valid && !item_take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (payload_len == 9'd0) begin
      len_eff = 9'd1;
    end else if (payload_len > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = payload_len;
    end
    len_m1  = len_eff - 9'd1;
    idx_inc = byte_index + 9'd1;
    is_last = idx_inc >= len_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      byte_index <= '0;
    end else if (accept) begin
      item_valid <= 1'b1;
      byte_index <= is_last ? 9'd0 : idx_inc;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.cmd      <= command_code;
      item.addr     <= device_addr;
      item.len_byte <= len_m1[7:0];
      item.data     <= data_byte;
      item.first    <= (byte_index == 9'd0);
      item.last     <= is_last;
    end
  end

endmodule

[src/crf_serial.sv]
`timescale 1ns / 1ps
// crf_serial: byte sequencer, running crc and output register
// depends on crf_pkg

module crf_serial (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  crf_pkg::item_t     item,
  output logic               item_take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               frame_end
);
  import crf_pkg::*;

  logic [15:0] crc_acc;
  logic [15:0] crc_next;
  logic [2:0]  ph;
  logic [2:0]  ph_next;
  logic [2:0]  cur_ph;
  logic        mid;
  logic        load_ok;
  logic        fire;
  logic        done;
  logic        end_bit;
  logic [7:0]  emit;

  assign load_ok   = !out_valid || !out_stall;
  assign fire      = load_ok && item_valid;
  assign item_take = fire && done;

  always_comb begin
    cur_ph   = mid ? ph : (item.first ? PH_CMD : PH_DATA);
    emit     = item.data;
    ph_next  = cur_ph;
    done     = 1'b0;
    end_bit  = 1'b0;
    crc_next = crc_acc;
    unique case (cur_ph)
      PH_CMD: begin
        emit     = item.cmd;
        ph_next  = PH_ADDR;
        crc_next = crc_fold(crc_acc, emit);
      end
      PH_ADDR: begin
        emit     = item.addr;
        ph_next  = PH_LEN;
        crc_next = crc_fold(crc_acc, emit);
      end
      PH_LEN: begin
        emit     = item.len_byte;
        ph_next  = PH_DATA;
        crc_next = crc_fold(crc_acc, emit);
      end
      PH_DATA: begin
        emit     = item.data;
        ph_next  = PH_CRCH;
        done     = !item.last;
        crc_next = crc_fold(crc_acc, emit);
      end
      PH_CRCH: begin
        emit    = crc_acc[15:8];
        ph_next = PH_CRCL;
      end
      PH_CRCL: begin
        emit     = crc_acc[7:0];
        done     = 1'b1;
        end_bit  = 1'b1;
        crc_next = 16'h0000;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid       <= 1'b0;
      ph        <= PH_CMD;
      crc_acc   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_ok) begin
        out_valid <= item_valid;
      end
      if (fire) begin
        mid     <= !done;
        ph      <= ph_next;
        crc_acc <= crc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte  <= emit;
      frame_end <= end_bit;
    end
  end

endmodule

[src/crc16_request_framer.sv]
`timescale 1ns / 1ps
// crc16_request_framer: top level of the crc-16 request framer
// depends on crf_pkg, crf_front and crf_serial
//
// usage
//   input channel (in_valid / in_stall) takes one payload byte per request,
//   with command_code, device_addr and payload_len alongside
//   the first byte of a frame produces command, address, length-1 and the
//   byte; middle bytes produce one byte; the last byte adds crc high and crc
//   low, the low byte marked by frame_end
//   output channel (out_valid / out_stall) gives one frame byte per cycle
//   an accepted request waits in the input register, then its first byte
//   goes to the single output register, which sets the rate: one byte per
//   cycle while out_stall is low; a middle payload byte is taken each such
//   cycle; a request that yields more than one byte holds the input until
//   its last byte is loaded; reset clears the crc, the frame position and
//   both valid flags; a stall on the output holds the current byte; the
//   input register then fills and the input stalls until bytes drain

module crc16_request_framer #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] command_code,
  input  logic [7:0] device_addr,
  input  logic [8:0] payload_len,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       frame_end
);
  import crf_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_take;

  crf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command_code(command_code),
    .device_addr (device_addr),
    .payload_len (payload_len),
    .data_byte   (data_byte),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take)
  );

  crf_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .frame_end (frame_end)
  );

endmodule
